// ----- hw/rtl/noise_voice_mixer_core_assert.svh -----
// assertion macros for the noise voice mixer
`ifndef NOISE_VOICE_MIXER_CORE_ASSERT_SVH
`define NOISE_VOICE_MIXER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NVM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nvm assertion failed");
`define NVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nvm assertion failed");
`else
`define NVM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define NVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/nvm_pkg.sv -----
// shared types and constants of the noise voice mixer
`timescale 1ns / 1ps
package nvm_pkg;

	typedef struct packed {
		logic               cmd;
		logic [14:0]        power;
		logic signed [15:0] power_step;
		logic signed [15:0] period_step;
		logic [15:0]        duration_ms;
		logic [15:0]        start_period;
	} item_t;

	typedef struct packed {
		logic [15:0] sample;
		logic [1:0]  voice;
		logic        started;
	} result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rem_stat_t;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_PLAY = 1'b1;

	localparam logic [1:0] CFG_ENVELOPE = 2'd0;
	localparam logic [1:0] CFG_SPM      = 2'd1;
	localparam logic [1:0] CFG_SEED     = 2'd2;

	localparam logic [15:0] ENV_RESET  = 16'd735;
	localparam logic [7:0]  SPM_RESET  = 8'd22;
	localparam logic [15:0] SEED_RESET = 16'd1;
	localparam logic [15:0] LFSR_TAPS  = 16'hB400;
	localparam logic [15:0] MIX_OFFSET = 16'h7FFF;
	localparam logic [4:0]  REM_STEPS  = 5'd16;

endpackage

// ----- hw/rtl/noise_voice_mixer_core.sv -----
// Noise voice mixer: a bank of noise voices summed into one offset-binary sample.
// Input channel item/item_valid/item_stall carries one item per transaction:
// cmd tick advances all active voices and returns the mixed sample, cmd play
// starts the lowest idle voice and returns its index and a started flag.
// Output channel result/result_valid/result_stall gives exactly one result per item.
// A play item passes through ST_PLAY and ST_DONE to the output register.
// A tick walks the voices one per cycle in ST_VOICE; a voice whose noise period
// expires holds the walk in ST_DRAW while it runs the shared 16-step remainder
// unit, and the tick then passes through ST_FIN and ST_DONE.
// One item is in work at a time: item_stall is high from acceptance until the
// result is handed to the output register, and the next item can be accepted
// in the cycle after that.
// The output register lets the next item be accepted while the previous result
// is still stalled; a finished result waits in the sequencer only while the
// output register is still full and stalled.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once and are
// meant for idle periods; writing the seed also reloads the noise register.
// Reset clears all voices, sets envelope_interval 735, samples_per_ms 22 and
// the noise register to 1; no result is pending after reset.
`timescale 1ns / 1ps
`include "noise_voice_mixer_core_assert.svh"
module noise_voice_mixer_core #(
	parameter int VOICES = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  nvm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output nvm_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data
);

	localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICES - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PLAY  = 3'd1;
	localparam logic [2:0] ST_VOICE = 3'd2;
	localparam logic [2:0] ST_DRAW  = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]        state_q;
	logic [VIDX_W-1:0] vidx_q;
	logic [15:0]       mix_q;
	nvm_pkg::item_t    item_q;
	nvm_pkg::result_t  pend_q;
	nvm_pkg::result_t  result_q;
	logic              result_valid_q;
	logic [15:0]       env_int_q;
	logic [7:0]        spm_q;
	logic [15:0]       half_q;

	logic [VOICES-1:0] active_q;
	logic [15:0]       level_q   [VOICES];
	logic [15:0]       power_q   [VOICES];
	logic [15:0]       pstep_q   [VOICES];
	logic [15:0]       period_q  [VOICES];
	logic [15:0]       perstep_q [VOICES];
	logic [15:0]       pcount_q  [VOICES];
	logic [15:0]       ecount_q  [VOICES];
	logic [31:0]       left_q    [VOICES];

	logic              accept;
	logic              out_load;
	logic              free_found;
	logic [VIDX_W-1:0] free_idx;
	logic [VIDX_W+1:0] free_wide;
	logic [23:0]       dur_prod;

	logic [31:0] left_dec;
	logic [15:0] pcount_dec;
	logic [15:0] ecount_dec;
	logic        do_draw;
	logic        do_env;
	logic [15:0] power_cur;
	logic [15:0] power_new;
	logic [15:0] period_new;
	logic        still_active;
	logic [15:0] mag;
	logic [15:0] half_tmp;
	logic [15:0] half_c;
	logic        voice_draw;
	logic [15:0] new_level;

	logic               seed_load;
	logic [15:0]        lfsr_next;
	nvm_pkg::rem_stat_t rem_stat;
	logic [15:0]        rem_result;

	assign accept       = item_valid && !item_stall;
	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_load     = (state_q == ST_DONE) && (!result_valid_q || !result_stall);
	assign seed_load    = cfg_we && (cfg_index == nvm_pkg::CFG_SEED);

	// lowest idle voice
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = VIDX_W'(i);
			end
		end
	end

	assign free_wide = {2'b00, free_idx};
	assign dur_prod  = 24'(item_q.duration_ms) * 24'(spm_q);

	// per-voice update for the voice under the walk pointer
	assign power_cur    = power_q[vidx_q];
	assign left_dec     = left_q[vidx_q] - 32'd1;
	assign pcount_dec   = pcount_q[vidx_q] - 16'd1;
	assign ecount_dec   = ecount_q[vidx_q] - 16'd1;
	assign do_draw      = (pcount_dec == 16'd0);
	assign do_env       = (ecount_dec == 16'd0);
	assign power_new    = power_cur + pstep_q[vidx_q];
	assign period_new   = period_q[vidx_q] + perstep_q[vidx_q];
	assign still_active = (left_dec != 32'd0) && !(do_env && power_new[15]);
	assign mag          = power_cur[15] ? (16'd0 - power_cur) : power_cur;
	// halve toward zero
	assign half_tmp     = power_cur + {15'd0, power_cur[15]};
	assign half_c       = {half_tmp[15], half_tmp[15:1]};
	assign voice_draw   = (state_q == ST_VOICE) && active_q[vidx_q] && do_draw;
	assign new_level    = rem_result - half_q;

	nvm_lfsr u_lfsr (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (seed_load),
		.seed   (cfg_data),
		.step   (voice_draw),
		.next   (lfsr_next)
	);

	nvm_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (voice_draw),
		.dividend (lfsr_next),
		.divisor  (mag),
		.stat     (rem_stat),
		.result   (rem_result)
	);

	// sequencer, config registers and reset-cleared voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			vidx_q         <= '0;
			result_valid_q <= 1'b0;
			env_int_q      <= nvm_pkg::ENV_RESET;
			spm_q          <= nvm_pkg::SPM_RESET;
			active_q       <= '0;
			for (int i = 0; i < VOICES; i++) begin
				level_q[i] <= 16'd0;
			end
		end else begin
			if (cfg_we && cfg_index == nvm_pkg::CFG_ENVELOPE) begin
				env_int_q <= cfg_data;
			end
			if (cfg_we && cfg_index == nvm_pkg::CFG_SPM) begin
				spm_q <= cfg_data[7:0];
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						vidx_q  <= '0;
						state_q <= (item.cmd == nvm_pkg::CMD_PLAY) ? ST_PLAY : ST_VOICE;
					end
				end
				ST_PLAY: begin
					if (free_found) begin
						active_q[free_idx] <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_VOICE: begin
					if (active_q[vidx_q]) begin
						active_q[vidx_q] <= still_active;
					end
					if (voice_draw) begin
						state_q <= ST_DRAW;
					end else if (vidx_q == LAST_VOICE) begin
						state_q <= ST_FIN;
					end else begin
						vidx_q <= vidx_q + VIDX_W'(1);
					end
				end
				ST_DRAW: begin
					if (rem_stat.done) begin
						level_q[vidx_q] <= new_level;
						if (vidx_q == LAST_VOICE) begin
							state_q <= ST_FIN;
						end else begin
							vidx_q  <= vidx_q + VIDX_W'(1);
							state_q <= ST_VOICE;
						end
					end
				end
				ST_FIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// voice payload, mix accumulator and pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			mix_q  <= 16'd0;
		end
		if (out_load) begin
			result_q <= pend_q;
		end
		case (state_q)
			ST_PLAY: begin
				if (free_found) begin
					power_q[free_idx]   <= {1'b0, item_q.power};
					pstep_q[free_idx]   <= item_q.power_step;
					perstep_q[free_idx] <= item_q.period_step;
					period_q[free_idx]  <= item_q.start_period;
					pcount_q[free_idx]  <= item_q.start_period;
					ecount_q[free_idx]  <= env_int_q;
					left_q[free_idx]    <= {8'd0, dur_prod};
				end
				pend_q.sample  <= 16'd0;
				pend_q.voice   <= free_found ? free_wide[1:0] : 2'd0;
				pend_q.started <= free_found;
			end
			ST_VOICE: begin
				if (active_q[vidx_q]) begin
					left_q[vidx_q]   <= left_dec;
					half_q           <= half_c;
					// reload uses the period from before this tick's sweep
					pcount_q[vidx_q] <= do_draw ? period_q[vidx_q] : pcount_dec;
					ecount_q[vidx_q] <= do_env ? env_int_q : ecount_dec;
					if (do_env) begin
						power_q[vidx_q]  <= power_new;
						period_q[vidx_q] <= period_new;
					end
					if (!do_draw) begin
						mix_q <= mix_q + level_q[vidx_q];
					end
				end
			end
			ST_DRAW: begin
				if (rem_stat.done) begin
					mix_q <= mix_q + new_level;
				end
			end
			ST_FIN: begin
				pend_q.sample  <= mix_q + nvm_pkg::MIX_OFFSET;
				pend_q.voice   <= 2'd0;
				pend_q.started <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	`NVM_ASSERT_IMPLY(a_rem_in_draw, clk, arst_n, rem_stat.busy || rem_stat.done, state_q == ST_DRAW)
	`NVM_ASSERT_NEXT(a_play_marks_voice, clk, arst_n, state_q == ST_PLAY && free_found, active_q[$past(free_idx)])
	`NVM_ASSERT_IMPLY(a_walk_in_range, clk, arst_n, state_q == ST_VOICE || state_q == ST_DRAW, vidx_q <= LAST_VOICE)
	`NVM_ASSERT_IMPLY(a_idle_no_draw, clk, arst_n, state_q == ST_IDLE, !rem_stat.busy)

endmodule

// ----- hw/rtl/nvm_lfsr.sv -----
// shared galois noise shift register with seed load
`timescale 1ns / 1ps
module nvm_lfsr (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [15:0] seed,
	input  logic        step,
	output logic [15:0] next
);

	logic [15:0] lfsr_q;

	assign next = lfsr_q[0] ? ({1'b0, lfsr_q[15:1]} ^ nvm_pkg::LFSR_TAPS)
	                        : {1'b0, lfsr_q[15:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= nvm_pkg::SEED_RESET;
		end else if (load) begin
			// an all-zero state would lock up
			lfsr_q <= (seed == 16'd0) ? 16'd1 : seed;
		end else if (step) begin
			lfsr_q <= next;
		end
	end

endmodule

// ----- hw/rtl/nvm_rem.sv -----
// iterative restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
module nvm_rem (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        dividend,
	input  logic [15:0]        divisor,
	output nvm_pkg::rem_stat_t stat,
	output logic [15:0]        result
);

	logic [15:0] dvd_q;
	logic [15:0] dvs_q;
	logic [15:0] rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic [16:0] diff;
	logic        fits;

	assign trial = {rem_q, dvd_q[15]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	// mod by zero gives zero
	assign result = (dvs_q == 16'd0) ? 16'd0 : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nvm_pkg::REM_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= 16'd0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[14:0], 1'b0};
			// remainder stays below the divisor, so 16 bits hold it
			rem_q <= fits ? diff[15:0] : trial[15:0];
		end
	end

endmodule

// ----- sim/tb_noise_voice_mixer_core.sv -----
// self-checking testbench of noise_voice_mixer_core against a voice bank predictor
`timescale 1ns / 1ps
module tb_noise_voice_mixer_core;

	localparam int VOICES      = 4;
	localparam int CYCLE_LIMIT = 1000000;
	// settle time after the last result has come back
	localparam int SETTLE      = 100;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_stall;
	nvm_pkg::item_t   item         = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	nvm_pkg::result_t result;
	logic             cfg_we       = 1'b0;
	logic [1:0]       cfg_index    = '0;
	logic [15:0]      cfg_data     = '0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatches     = 0;

	// predicted voice bank
	logic        on_q      [VOICES];
	logic [15:0] pwr_q     [VOICES];
	logic [15:0] pstep_q   [VOICES];
	logic [15:0] per_q     [VOICES];
	logic [15:0] pcnt_q    [VOICES];
	logic [15:0] ecnt_q    [VOICES];
	logic [15:0] perstep_q [VOICES];
	logic [15:0] lvl_q     [VOICES];
	logic [31:0] left_q    [VOICES];
	logic [15:0] noise_reg;
	logic [15:0] env_reg;
	logic [7:0]  spm_reg;

	nvm_pkg::result_t voice_replies[$];

	noise_voice_mixer_core #(.VOICES(VOICES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_results
		nvm_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (voice_replies.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing outstanding", result));
			end else begin
				want = voice_replies.pop_front();
				if (result.sample !== want.sample)
					report_mismatch($sformatf("sample %h, want %h", result.sample, want.sample));
				if (result.voice !== want.voice)
					report_mismatch($sformatf("voice %h, want %h", result.voice, want.voice));
				if (result.started !== want.started)
					report_mismatch($sformatf("started %b, want %b", result.started, want.started));
			end
		end
	end

	task automatic clear_bank();
		for (int v = 0; v < VOICES; v++) begin
			on_q[v]      = 1'b0;
			pwr_q[v]     = '0;
			pstep_q[v]   = '0;
			per_q[v]     = '0;
			pcnt_q[v]    = '0;
			ecnt_q[v]    = '0;
			perstep_q[v] = '0;
			lvl_q[v]     = '0;
			left_q[v]    = '0;
		end
		env_reg   = nvm_pkg::ENV_RESET;
		spm_reg   = nvm_pkg::SPM_RESET;
		noise_reg = nvm_pkg::SEED_RESET;
	endtask

	// steps the shared shift register and draws a level within the voice's power span
	function automatic logic [15:0] noise_level(input logic [15:0] pw);
		int span;
		int mag;
		int m;
		noise_reg = noise_reg[0] ? ((noise_reg >> 1) ^ nvm_pkg::LFSR_TAPS) : (noise_reg >> 1);
		span = $signed(pw);
		mag = (span < 0) ? -span : span;
		m = (mag == 0) ? 0 : int'(noise_reg) % mag;
		return 16'(m - span / 2);
	endfunction

	function automatic nvm_pkg::result_t advance_voices(input nvm_pkg::item_t it);
		nvm_pkg::result_t r;
		logic [15:0] mix;
		bit found;
		r = '0;
		mix = '0;
		found = 1'b0;
		if (it.cmd == nvm_pkg::CMD_TICK) begin
			for (int v = 0; v < VOICES; v++) begin
				if (on_q[v]) begin
					left_q[v] = left_q[v] - 32'd1;
					pcnt_q[v] = pcnt_q[v] - 16'd1;
					ecnt_q[v] = ecnt_q[v] - 16'd1;
					if (left_q[v] == 32'd0) on_q[v] = 1'b0;
					if (pcnt_q[v] == 16'd0) begin
						pcnt_q[v] = per_q[v];
						lvl_q[v] = noise_level(pwr_q[v]);
					end
					if (ecnt_q[v] == 16'd0) begin
						ecnt_q[v] = env_reg;
						pwr_q[v] = pwr_q[v] + pstep_q[v];
						if (pwr_q[v][15]) on_q[v] = 1'b0;
						per_q[v] = per_q[v] + perstep_q[v];
					end
					// a voice that stopped this tick still adds its level
					mix = mix + lvl_q[v];
				end
			end
			r.sample = mix + nvm_pkg::MIX_OFFSET;
		end else begin
			for (int v = 0; v < VOICES; v++) begin
				if (!on_q[v] && !found) begin
					found        = 1'b1;
					pstep_q[v]   = it.power_step;
					perstep_q[v] = it.period_step;
					per_q[v]     = it.start_period;
					pcnt_q[v]    = it.start_period;
					pwr_q[v]     = {1'b0, it.power};
					ecnt_q[v]    = env_reg;
					left_q[v]    = 32'(it.duration_ms) * 32'(spm_reg);
					on_q[v]      = 1'b1;
					r.voice      = 2'(v);
					r.started    = 1'b1;
				end
			end
		end
		return r;
	endfunction

	task automatic send_item(input nvm_pkg::item_t it);
		int gap;
		if ($urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 3);
			repeat (gap) begin
				@(negedge clk);
				item_valid <= 1'b0;
			end
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		voice_replies.push_back(advance_voices(it));
	endtask

	// drop valid and let every outstanding transaction come back
	task automatic wait_idle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (voice_replies.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_register(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			nvm_pkg::CFG_ENVELOPE: env_reg = val;
			nvm_pkg::CFG_SPM:      spm_reg = val[7:0];
			nvm_pkg::CFG_SEED:     noise_reg = (val == 16'd0) ? 16'd1 : val;
			default: ;
		endcase
	endtask

	function automatic nvm_pkg::item_t make_item(input logic cmd, input logic [14:0] pw,
		input logic [15:0] pstep, input logic [15:0] perstep, input logic [15:0] dur,
		input logic [15:0] per);
		nvm_pkg::item_t it;
		it.cmd          = cmd;
		it.power        = pw;
		it.power_step   = pstep;
		it.period_step  = perstep;
		it.duration_ms  = dur;
		it.start_period = per;
		return it;
	endfunction

	task automatic send_ticks(input int n);
		repeat (n) send_item(make_item(nvm_pkg::CMD_TICK, '0, '0, '0, '0, '0));
	endtask

	function automatic nvm_pkg::item_t random_item(input bit long_ok, input int dur_hi);
		nvm_pkg::item_t it;
		int pick;
		it.cmd = ($urandom_range(99) < 30) ? nvm_pkg::CMD_PLAY : nvm_pkg::CMD_TICK;
		pick = $urandom_range(9);
		if (pick == 0) it.power = '0;
		else if (pick < 5) it.power = 15'($urandom_range(1, 400));
		else it.power = 15'($urandom);
		it.power_step = $urandom_range(1) ? 16'($urandom) : 16'(-$urandom_range(1, 64));
		it.period_step = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6) - 3);
		if (long_ok && $urandom_range(9) == 0) begin
			// long or endless voice, ended by a steep power fall
			it.duration_ms = $urandom_range(1) ? 16'd0 : 16'($urandom);
			it.power_step = 16'(-$urandom_range(1024, 32768));
		end else begin
			it.duration_ms = 16'($urandom_range(1, dur_hi));
		end
		pick = $urandom_range(19);
		if (pick == 0) it.start_period = '0;
		else if (pick < 4) it.start_period = 16'($urandom);
		else it.start_period = 16'($urandom_range(1, 6));
		return it;
	endfunction

	task automatic test_idle_mix();
		set_register(nvm_pkg::CFG_SEED, 16'd0);
		set_register(nvm_pkg::CFG_ENVELOPE, 16'd2);
		set_register(nvm_pkg::CFG_SPM, 16'd1);
		send_ticks(2);
	endtask

	task automatic test_voice_allocation();
		// power wrap past the top, zero power, zero period, full step swings
		send_item(make_item(nvm_pkg::CMD_PLAY, 15'h7fff, 16'd1, 16'd0, 16'd0, 16'd1));
		send_item(make_item(nvm_pkg::CMD_PLAY, 15'd0, 16'd0, 16'd0, 16'd3, 16'd1));
		send_item(make_item(nvm_pkg::CMD_PLAY, 15'd100, -16'sd200, 16'h8000, 16'hffff, 16'd0));
		send_item(make_item(nvm_pkg::CMD_PLAY, 15'd1000, 16'h7fff, 16'h7fff, 16'd2, 16'hffff));
		// bank full
		send_item(make_item(nvm_pkg::CMD_PLAY, 15'd5, -16'sd1, 16'd1, 16'd1, 16'd1));
	endtask

	task automatic test_sweep_and_stop();
		send_ticks(6);
	endtask

	task automatic test_restart_level();
		// voice 0 comes back holding its old level until the first draw
		send_item(make_item(nvm_pkg::CMD_PLAY, 15'd50, -16'sd1, 16'd2, 16'd4, 16'd3));
		send_ticks(4);
	endtask

	task automatic test_zero_rate();
		wait_idle();
		set_register(nvm_pkg::CFG_SPM, 16'd0);
		set_register(CFG_UNUSED, 16'h0005);
		send_item(make_item(nvm_pkg::CMD_PLAY, 15'd5, 16'h8000, 16'd0, 16'd7, 16'd2));
		send_ticks(3);
	endtask

	task automatic test_random_traffic(input int count, input logic [15:0] env,
		input logic [7:0] spm, input logic [15:0] seed, input bit long_ok, input int dur_hi);
		wait_idle();
		set_register(nvm_pkg::CFG_ENVELOPE, env);
		set_register(nvm_pkg::CFG_SPM, {8'd0, spm});
		set_register(nvm_pkg::CFG_SEED, seed);
		repeat (count) send_item(random_item(long_ok, dur_hi));
	endtask

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin
		clear_bank();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct  = 8;
		recv_stall_pct = 58;
		test_idle_mix();
		test_voice_allocation();
		test_sweep_and_stop();
		test_restart_level();
		test_zero_rate();
		test_random_traffic(150, 16'd1, 8'd1, 16'($urandom_range(1, 65535)), 1'b0, 16);
		test_random_traffic(150, 16'd5, 8'd3, 16'hffff, 1'b1, 10);

		send_idle_pct  = 58;
		recv_stall_pct = 8;
		test_random_traffic(150, 16'hffff, 8'd255, 16'd1, 1'b0, 1);
		test_random_traffic(150, 16'd0, 8'd2, 16'($urandom_range(1, 65535)), 1'b0, 12);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_traffic(150, 16'd3, 8'd1, 16'($urandom_range(1, 65535)), 1'b1, 20);
		test_random_traffic(150, 16'd2, 8'd4, 16'($urandom_range(1, 65535)), 1'b1, 8);

		wait_idle();
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
